FILE: rtl/core/qec_pkg.sv
// Shared types, codes and constants of the quadrature encoder counter.
package qec_pkg;

   // Datapath widths.
   localparam int COUNT_W = 32;
   localparam int TIME_W  = 32;

   // Command codes of an input word.
   localparam logic [1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [1:0] CMD_ZERO       = 2'd1;
   localparam logic [1:0] CMD_ZERO_INDEX = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_QUAD_MODE     = 2'd0;
   localparam logic [1:0] REG_COUNTS_PER_REV = 2'd1;
   localparam logic [1:0] REG_INDEX_ENABLE  = 2'd2;
   localparam logic [1:0] REG_STALE_TIMEOUT = 2'd3;

   // Configuration reset values.
   localparam logic        RST_QUAD_MODE     = 1'b1;
   localparam logic [15:0] RST_COUNTS_PER_REV = 16'd2048;
   localparam logic        RST_INDEX_ENABLE  = 1'b0;
   localparam logic [23:0] RST_STALE_TIMEOUT = 24'd150000;

   // Depth of the queue between front and back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Shared divider geometry.
   localparam int DIV_NW = 64;
   localparam int DIV_DW = 35;
   localparam int DIV_CW = $clog2(DIV_NW + 1);

   // 256 * 1e6 * 2: Q.8 scaling of counts per microsecond, doubled for rounding.
   localparam logic [28:0] VEL_SCALE = 29'd512000000;

   typedef struct packed {
      logic [1:0]        cmd;
      logic              pin_a;
      logic              pin_b;
      logic              pin_index;
      logic [TIME_W-1:0] now_us;
      logic              velocity_request;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] position_count;
      logic                      index_found;
      logic signed [COUNT_W-1:0] index_offset;
      logic signed [31:0]        counts_per_second;
   } rsp_type;

   typedef struct packed {
      logic        quadrature_mode;
      logic [15:0] counts_per_rev;
      logic        index_enable;
      logic [23:0] stale_timeout_us;
   } cfg_type;

   typedef struct packed {
      req_type req;
      logic    is_sample;
      logic    is_zero;
      logic    is_zero_index;
   } work_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_NW-1:0] quo;
   } div_rsp_type;

endpackage

FILE: rtl/core/qec_front.sv
// Input queue of the encoder counter that decodes each command word.
module qec_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  qec_pkg::req_type   req_data,
   output logic               work_valid,
   input  logic               work_pop,
   output qec_pkg::work_type  work
);

   qec_pkg::work_type                qbuf_ff [qec_pkg::QDEPTH];
   logic [qec_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [qec_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [qec_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   qec_pkg::work_type                decoded;
   logic                             do_push;

   assign full       = (fill_ff == qec_pkg::QCNT_W'(qec_pkg::QDEPTH));
   assign work_valid = (fill_ff != '0);
   assign work       = qbuf_ff[rd_ptr_ff];
   assign do_push    = push && !full;

   always_comb begin
      decoded.req           = req_data;
      decoded.is_sample     = (req_data.cmd == qec_pkg::CMD_SAMPLE);
      decoded.is_zero       = (req_data.cmd == qec_pkg::CMD_ZERO);
      decoded.is_zero_index = (req_data.cmd == qec_pkg::CMD_ZERO_INDEX);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == qec_pkg::QPTR_W'(qec_pkg::QDEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (work_pop) begin
         rd_ptr_in = (rd_ptr_ff == qec_pkg::QPTR_W'(qec_pkg::QDEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (do_push && !work_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && work_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         qbuf_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: rtl/core/qec_div.sv
// Restoring divider, one quotient bit per cycle, shared by alignment and velocity.
module qec_div (
   input  logic                  clock,
   input  logic                  reset,
   input  qec_pkg::div_req_type  div_req,
   output qec_pkg::div_rsp_type  div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [qec_pkg::DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [qec_pkg::DIV_DW-1:0]   rem_ff, rem_in;
   logic [qec_pkg::DIV_NW-1:0]   quo_ff, quo_in;
   logic [qec_pkg::DIV_DW-1:0]   den_ff, den_in;
   logic [qec_pkg::DIV_DW:0]     rem_sh;
   logic [qec_pkg::DIV_DW:0]     diff;
   logic                         ge;

   assign rem_sh = {rem_ff, quo_ff[qec_pkg::DIV_NW-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = qec_pkg::DIV_CW'(qec_pkg::DIV_NW);
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[qec_pkg::DIV_DW-1:0] : rem_sh[qec_pkg::DIV_DW-1:0];
         quo_in = {quo_ff[qec_pkg::DIV_NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == qec_pkg::DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

FILE: rtl/core/qec_back.sv
// Counter state, index alignment and velocity sequencer with the result register.
module qec_back (
   input  logic                  clock,
   input  logic                  reset,
   input  qec_pkg::cfg_type      cfg,
   input  logic                  work_valid,
   output logic                  work_pop,
   input  qec_pkg::work_type     work,
   output qec_pkg::div_req_type  div_req,
   input  qec_pkg::div_rsp_type  div_rsp,
   output logic                  empty,
   input  logic                  pop,
   output qec_pkg::rsp_type      rsp_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ALN_GO   = 4'd1;
   localparam logic [3:0] S_ALN_WAIT = 4'd2;
   localparam logic [3:0] S_ALN_MUL  = 4'd3;
   localparam logic [3:0] S_ALN_FIX  = 4'd4;
   localparam logic [3:0] S_B        = 4'd5;
   localparam logic [3:0] S_VEL      = 4'd6;
   localparam logic [3:0] S_VEL_MUL  = 4'd7;
   localparam logic [3:0] S_VEL_GO   = 4'd8;
   localparam logic [3:0] S_VEL_WAIT = 4'd9;
   localparam logic [3:0] S_VEL_FIN  = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   localparam int CW = qec_pkg::COUNT_W;
   localparam int TW = qec_pkg::TIME_W;

   logic [3:0]    state_ff, state_in;
   logic          a_level_ff, a_level_in;
   logic          b_level_ff, b_level_in;
   logic          index_level_ff, index_level_in;
   logic [CW-1:0] count_ff, count_in;
   logic          index_seen_ff, index_seen_in;
   logic [CW-1:0] index_count_ff, index_count_in;
   logic [TW-1:0] last_edge_ff, last_edge_in;
   logic [CW-1:0] prev_count_ff, prev_count_in;
   logic [TW-1:0] prev_sample_ff, prev_sample_in;
   logic [TW-1:0] prev_since_ff, prev_since_in;
   logic [31:0]   rate_ff, rate_in;
   logic          rsp_valid_ff, rsp_valid_in;
   qec_pkg::rsp_type  rsp_ff, rsp_in;
   qec_pkg::work_type cur_ff, cur_in;
   logic [CW-1:0] aln_q_ff, aln_q_in;
   logic [CW-1:0] aln_n_ff, aln_n_in;
   logic [TW-1:0] vel_th_ff, vel_th_in;
   logic [TW+1:0] vel_dt_ff, vel_dt_in;
   logic          vel_neg_ff, vel_neg_in;
   logic [CW-1:0] vel_mag_ff, vel_mag_in;
   logic [CW+28:0] vel_prod_ff, vel_prod_in;

   logic          slot_free;
   logic [CW+15:0] aln_prod;

   // Returns {edge seen, step down} for a change on channel A.
   function automatic logic [1:0] a_step(input logic quad, input logic pa,
                                         input logic a_old, input logic b_old,
                                         input logic pb);
      logic [1:0] r;
      r = 2'b00;
      if (quad) begin
         if (pa != a_old) r = {1'b1, (a_old != b_old)};
      end else if (pa && !a_old && !pb) begin
         r = 2'b10;
      end
      return r;
   endfunction

   // Returns {edge seen, step down} for a change on channel B.
   function automatic logic [1:0] b_step(input logic quad, input logic a_new,
                                         input logic b_old, input logic pb);
      logic [1:0] r;
      r = 2'b00;
      if (quad) begin
         if (pb != b_old) r = {1'b1, (a_new == b_old)};
      end else if (pb && !b_old && !a_new) begin
         r = 2'b11;
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
      return v[CW-1] ? (CW'(0) - v) : v;
   endfunction

   assign slot_free = !rsp_valid_ff || pop;
   assign aln_prod  = aln_q_ff * cfg.counts_per_rev;

   always_comb begin
      logic [1:0]    st;
      logic [CW-1:0] c1;
      logic [CW-1:0] n;
      logic          fin;
      logic          need_aln;
      logic [TW-1:0] ts;
      logic [TW-1:0] th;
      logic [TW+2:0] dt;
      logic [CW-1:0] dn;
      logic [qec_pkg::DIV_NW-1:0] lim;
      logic [31:0]   v32;

      state_in       = state_ff;
      a_level_in     = a_level_ff;
      b_level_in     = b_level_ff;
      index_level_in = index_level_ff;
      count_in       = count_ff;
      index_seen_in  = index_seen_ff;
      index_count_in = index_count_ff;
      last_edge_in   = last_edge_ff;
      prev_count_in  = prev_count_ff;
      prev_sample_in = prev_sample_ff;
      prev_since_in  = prev_since_ff;
      rate_in        = rate_ff;
      rsp_valid_in   = rsp_valid_ff && !pop;
      rsp_in         = rsp_ff;
      cur_in         = cur_ff;
      aln_q_in       = aln_q_ff;
      aln_n_in       = aln_n_ff;
      vel_th_in      = vel_th_ff;
      vel_dt_in      = vel_dt_ff;
      vel_neg_in     = vel_neg_ff;
      vel_mag_in     = vel_mag_ff;
      vel_prod_in    = vel_prod_ff;
      work_pop       = 1'b0;
      div_req        = '0;
      st             = 2'b00;
      c1             = count_ff;
      n              = '0;
      fin            = 1'b0;
      need_aln       = 1'b0;
      ts             = prev_sample_ff;
      th             = last_edge_ff;
      dt             = '0;
      dn             = '0;
      lim            = '0;
      v32            = '0;

      case (state_ff)
         S_IDLE: begin
            if (work_valid && slot_free) begin
               work_pop = 1'b1;
               cur_in   = work;
               fin      = 1'b1;
               if (work.is_sample) begin
                  st = a_step(cfg.quadrature_mode, work.req.pin_a, a_level_ff, b_level_ff,
                              work.req.pin_b);
                  if (st[1]) begin
                     c1           = st[0] ? (count_ff - 1'b1) : (count_ff + 1'b1);
                     last_edge_in = work.req.now_us;
                  end
                  a_level_in = work.req.pin_a;
                  if (cfg.index_enable) begin
                     index_level_in = work.req.pin_index;
                     if (work.req.pin_index && !index_level_ff) begin
                        if (!index_seen_ff) begin
                           index_seen_in  = 1'b1;
                           index_count_in = c1;
                        end else if (cfg.counts_per_rev != '0) begin
                           need_aln = 1'b1;
                        end
                     end
                  end
                  count_in = c1;
                  if (need_aln) begin
                     fin      = 1'b0;
                     state_in = S_ALN_GO;
                  end else begin
                     st = b_step(cfg.quadrature_mode, work.req.pin_a, b_level_ff,
                                 work.req.pin_b);
                     if (st[1]) begin
                        count_in     = st[0] ? (c1 - 1'b1) : (c1 + 1'b1);
                        last_edge_in = work.req.now_us;
                     end
                     b_level_in = work.req.pin_b;
                  end
               end else if (work.is_zero) begin
                  count_in     = '0;
                  last_edge_in = work.req.now_us;
               end else if (work.is_zero_index) begin
                  count_in      = count_ff - index_count_ff;
                  prev_count_in = count_ff - index_count_ff;
               end
               if (fin) begin
                  if (work.req.velocity_request) begin
                     state_in = S_VEL;
                  end else begin
                     rsp_valid_in             = 1'b1;
                     rsp_in.position_count    = count_in;
                     rsp_in.index_found       = index_seen_in;
                     rsp_in.index_offset      = index_count_in;
                     rsp_in.counts_per_second = rate_ff;
                  end
               end
            end
         end
         S_ALN_GO: begin
            // Nearest multiple, ties away from zero: floor((2m + cpr) / (2 cpr)).
            div_req.start = 1'b1;
            div_req.num   = {31'd0, mag(count_ff), 1'b0} + {48'd0, cfg.counts_per_rev};
            div_req.den   = {18'd0, cfg.counts_per_rev, 1'b0};
            state_in      = S_ALN_WAIT;
         end
         S_ALN_WAIT: begin
            if (div_rsp.done) begin
               aln_q_in = div_rsp.quo[CW-1:0];
               state_in = S_ALN_MUL;
            end
         end
         S_ALN_MUL: begin
            aln_n_in = aln_prod[CW-1:0];
            state_in = S_ALN_FIX;
         end
         S_ALN_FIX: begin
            n             = count_ff[CW-1] ? (CW'(0) - aln_n_ff) : aln_n_ff;
            count_in      = n;
            prev_count_in = n + count_ff - prev_count_ff;
            state_in      = S_B;
         end
         S_B: begin
            st = b_step(cfg.quadrature_mode, cur_ff.req.pin_a, b_level_ff, cur_ff.req.pin_b);
            if (st[1]) begin
               count_in     = st[0] ? (count_ff - 1'b1) : (count_ff + 1'b1);
               last_edge_in = cur_ff.req.now_us;
            end
            b_level_in = cur_ff.req.pin_b;
            state_in   = cur_ff.req.velocity_request ? S_VEL : S_OUT;
         end
         S_VEL: begin
            ts         = cur_ff.req.now_us - prev_sample_ff;
            th         = cur_ff.req.now_us - last_edge_ff;
            dt         = {3'd0, ts} + {3'd0, prev_since_ff} - {3'd0, th};
            dn         = count_ff - prev_count_ff;
            vel_th_in  = th;
            vel_dt_in  = dt[TW+1:0];
            vel_neg_in = dn[CW-1];
            vel_mag_in = mag(dn);
            if ((dn != '0) && !dt[TW+2] && (dt != '0) &&
                ({dt[TW+1:0], 1'b0} > {3'd0, ts})) begin
               state_in = S_VEL_MUL;
            end else begin
               state_in = S_VEL_FIN;
            end
         end
         S_VEL_MUL: begin
            vel_prod_in = vel_mag_ff * qec_pkg::VEL_SCALE;
            state_in    = S_VEL_GO;
         end
         S_VEL_GO: begin
            // Q.8 rate rounded half up: floor((512e6 * |dN| + dt) / (2 dt)).
            div_req.start = 1'b1;
            div_req.num   = {3'd0, vel_prod_ff} + {30'd0, vel_dt_ff};
            div_req.den   = {vel_dt_ff, 1'b0};
            state_in      = S_VEL_WAIT;
         end
         S_VEL_WAIT: begin
            if (div_rsp.done) begin
               lim      = vel_neg_ff ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
               v32      = (div_rsp.quo > lim) ? lim[31:0] : div_rsp.quo[31:0];
               rate_in  = vel_neg_ff ? (32'd0 - v32) : v32;
               state_in = S_VEL_FIN;
            end
         end
         S_VEL_FIN: begin
            if (vel_th_ff > {8'd0, cfg.stale_timeout_us}) begin
               rate_in = '0;
            end
            prev_sample_in = cur_ff.req.now_us;
            prev_since_in  = vel_th_ff;
            prev_count_in  = count_ff;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.position_count    = count_ff;
               rsp_in.index_found       = index_seen_ff;
               rsp_in.index_offset      = index_count_ff;
               rsp_in.counts_per_second = rate_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         a_level_ff     <= 1'b0;
         b_level_ff     <= 1'b0;
         index_level_ff <= 1'b0;
         count_ff       <= '0;
         index_seen_ff  <= 1'b0;
         index_count_ff <= '0;
         last_edge_ff   <= '0;
         prev_count_ff  <= '0;
         prev_sample_ff <= '0;
         prev_since_ff  <= '0;
         rate_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         a_level_ff     <= a_level_in;
         b_level_ff     <= b_level_in;
         index_level_ff <= index_level_in;
         count_ff       <= count_in;
         index_seen_ff  <= index_seen_in;
         index_count_ff <= index_count_in;
         last_edge_ff   <= last_edge_in;
         prev_count_ff  <= prev_count_in;
         prev_sample_ff <= prev_sample_in;
         prev_since_ff  <= prev_since_in;
         rate_ff        <= rate_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      cur_ff      <= cur_in;
      aln_q_ff    <= aln_q_in;
      aln_n_ff    <= aln_n_in;
      vel_th_ff   <= vel_th_in;
      vel_dt_ff   <= vel_dt_in;
      vel_neg_ff  <= vel_neg_in;
      vel_mag_ff  <= vel_mag_in;
      vel_prod_ff <= vel_prod_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Words leave the queue only when the sequencer is idle.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> (state_ff == S_IDLE))
      else $error("queue popped outside idle");

   // A finished item always lands in the result register.
   a_out_lands: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && slot_free) |=> rsp_valid_ff)
      else $error("result lost on write");

   // Once found, the index stays found until reset.
   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(index_seen_ff))
      else $error("index found flag dropped");

endmodule

FILE: rtl/core/quadrature_encoder_counter.sv
// Top level of the quadrature encoder counter with index alignment and velocity.
//
//   Channel   Ports                                  Direction  Handshake
//   sample    push, full, req_data                   in         push && !full
//   result    empty, pop, rsp_data                   out        pop && !empty
//   config    csr_valid, csr_ready, csr_index/wdata  in         csr_valid && csr_ready
//
// A pin sample or command word without index alignment or velocity request is handled
// in one pass of the idle state, so such words stream at one per clock while the result
// register is free or being popped. An accepted word passes through the input queue
// and then the result register on its way to the result ports. An index edge that needs
// alignment adds a divider load, the 64-bit quotient of the shared bit-serial divider,
// then the done, multiply, fixup and channel B steps. A velocity request adds setup
// steps, the divider and the stale check, or skips the division when the estimate
// holds without one. Reset is synchronous and active high; it clears all counter state
// and loads the register defaults. The result register and the two-entry input queue
// let either side stall on its own, and configuration writes are always accepted.
module quadrature_encoder_counter (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  qec_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output qec_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   // Configuration registers.
   qec_pkg::cfg_type cfg_ff, cfg_in;

   // Front to back word queue.
   logic              work_valid;
   logic              work_pop;
   qec_pkg::work_type work;

   // Divider port.
   qec_pkg::div_req_type div_req;
   qec_pkg::div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   // Each write updates one register; the unused high data bits are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            qec_pkg::REG_QUAD_MODE:      cfg_in.quadrature_mode  = csr_wdata[0];
            qec_pkg::REG_COUNTS_PER_REV: cfg_in.counts_per_rev   = csr_wdata[15:0];
            qec_pkg::REG_INDEX_ENABLE:   cfg_in.index_enable     = csr_wdata[0];
            qec_pkg::REG_STALE_TIMEOUT:  cfg_in.stale_timeout_us = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quadrature_mode  <= qec_pkg::RST_QUAD_MODE;
         cfg_ff.counts_per_rev   <= qec_pkg::RST_COUNTS_PER_REV;
         cfg_ff.index_enable     <= qec_pkg::RST_INDEX_ENABLE;
         cfg_ff.stale_timeout_us <= qec_pkg::RST_STALE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end queues and decodes incoming words.
   qec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work)
   );

   // One divider serves both index alignment and the velocity quotient.
   qec_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The back end holds the counter state and the result register.
   qec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
